// File: design/channel_range_list_to_mask_assert.svh
// assertion macros for the channel range list parser
`ifndef CHANNEL_RANGE_LIST_TO_MASK_ASSERT_SVH
`define CHANNEL_RANGE_LIST_TO_MASK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, off while reset is high
`define CLRM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked during reset too
`define CLRM_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CLRM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CLRM_ASSERT_NEXT(label, clk, ante, cons)

`endif

`endif

// File: design/clrm_pkg.sv
`default_nettype none

package clrm_pkg;

   localparam int MAX_CHANNELS_DEFAULT = 64;

   localparam int CHAR_W   = 8;
   localparam int MASK_W   = 64;
   localparam int STATUS_W = 3;
   localparam int ACC_W    = 7;
   localparam int IDX_W    = 6;
   localparam int DIGIT_W  = 4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CLS_END,
      CLS_BLANK,
      CLS_DIGIT,
      CLS_HYPHEN,
      CLS_COMMA,
      CLS_OTHER
   } char_class_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_DIGIT     = 3'd1,
      ST_RANGE     = 3'd2,
      ST_HYPHEN    = 3'd3,
      ST_SEPARATOR = 3'd4
   } status_type;

   typedef struct packed {
      char_class_type      cls;
      logic [DIGIT_W-1:0]  digit;
   } char_item_type;

endpackage

`default_nettype wire

// File: design/clrm_front.sv
`default_nettype none

module clrm_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [clrm_pkg::CHAR_W-1:0]   req_character,
   output logic                               item_valid,
   input  wire logic                          item_ready,
   output clrm_pkg::char_item_type            item
);

   localparam logic [clrm_pkg::CHAR_W-1:0] CHAR_NUL    = 8'd0;
   localparam logic [clrm_pkg::CHAR_W-1:0] CHAR_SPACE  = 8'd32;
   localparam logic [clrm_pkg::CHAR_W-1:0] CHAR_TAB    = 8'd9;
   localparam logic [clrm_pkg::CHAR_W-1:0] CHAR_CR     = 8'd13;
   localparam logic [clrm_pkg::CHAR_W-1:0] CHAR_ZERO   = 8'd48;
   localparam logic [clrm_pkg::CHAR_W-1:0] CHAR_NINE   = 8'd57;
   localparam logic [clrm_pkg::CHAR_W-1:0] CHAR_HYPHEN = 8'd45;
   localparam logic [clrm_pkg::CHAR_W-1:0] CHAR_COMMA  = 8'd44;

   logic                      valid_ff, valid_in;
   clrm_pkg::char_item_type   item_ff, item_in;
   clrm_pkg::char_item_type   cls_item;
   logic [clrm_pkg::CHAR_W-1:0] digit_full;

   assign digit_full = req_character - CHAR_ZERO;

   always_comb begin
      cls_item.digit = digit_full[clrm_pkg::DIGIT_W-1:0];
      priority if (req_character == CHAR_NUL) begin
         cls_item.cls = clrm_pkg::CLS_END;
      end else if (req_character == CHAR_SPACE ||
                   (req_character >= CHAR_TAB && req_character <= CHAR_CR)) begin
         cls_item.cls = clrm_pkg::CLS_BLANK;
      end else if (req_character >= CHAR_ZERO && req_character <= CHAR_NINE) begin
         cls_item.cls = clrm_pkg::CLS_DIGIT;
      end else if (req_character == CHAR_HYPHEN) begin
         cls_item.cls = clrm_pkg::CLS_HYPHEN;
      end else if (req_character == CHAR_COMMA) begin
         cls_item.cls = clrm_pkg::CLS_COMMA;
      end else begin
         cls_item.cls = clrm_pkg::CLS_OTHER;
      end
   end

   assign req_ready = !valid_ff || item_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (valid_ff && item_ready) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         item_in  = cls_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// File: design/clrm_queue.sv
`default_nettype none

module clrm_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push_valid,
   output logic                           push_ready,
   input  wire clrm_pkg::char_item_type   push_item,
   output logic                           pop_valid,
   input  wire logic                      pop_ready,
   output clrm_pkg::char_item_type        pop_item
);

   localparam int PW = clrm_pkg::QUEUE_PTR_W;
   localparam int CW = clrm_pkg::QUEUE_CNT_W;
   localparam logic [PW-1:0] LAST_PTR = PW'(clrm_pkg::QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(clrm_pkg::QUEUE_DEPTH);

   clrm_pkg::char_item_type entry_ff [clrm_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: design/clrm_back.sv
`default_nettype none

module clrm_back #(
   parameter int MAX_CHANNELS = clrm_pkg::MAX_CHANNELS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            item_valid,
   output logic                                 item_ready,
   input  wire clrm_pkg::char_item_type         item,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [clrm_pkg::MASK_W-1:0]          rsp_channel_mask,
   output logic [clrm_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int AW = clrm_pkg::ACC_W;
   localparam int IW = clrm_pkg::IDX_W;
   localparam int VW = 10;
   localparam logic [VW-1:0] MAX_V = VW'(MAX_CHANNELS);

   typedef enum logic [1:0] {
      PH_EXPECT,
      PH_SPACED,
      PH_NUMBER,
      PH_AFTER
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [AW-1:0]                 acc_ff, acc_in;
   logic                          ovf_ff, ovf_in;
   logic                          range_open_ff, range_open_in;
   logic [IW-1:0]                 range_low_ff, range_low_in;
   logic [MAX_CHANNELS-1:0]       mask_ff, mask_in;
   clrm_pkg::status_type          err_ff, err_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [clrm_pkg::MASK_W-1:0]   rsp_mask_ff, rsp_mask_in;
   clrm_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic [AW-1:0]                 acc_m1;
   logic [IW-1:0]                 hi_raw, lo_raw, span_lo, span_hi;
   logic [MAX_CHANNELS-1:0]       span_mask, closed_mask;
   logic                          number_ok;
   logic [VW-1:0]                 digit_v, next_v;
   logic                          out_free;
   clrm_pkg::status_type          end_err;
   logic [MAX_CHANNELS-1:0]       end_mask;

   // range covered by the finished number, swapped when reversed
   assign acc_m1  = acc_ff - AW'(1);
   assign hi_raw  = acc_m1[IW-1:0];
   assign lo_raw  = range_open_ff ? range_low_ff : hi_raw;
   assign span_lo = (lo_raw > hi_raw) ? hi_raw : lo_raw;
   assign span_hi = (lo_raw > hi_raw) ? lo_raw : hi_raw;

   always_comb begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         span_mask[i] = (IW'(i) >= span_lo) && (IW'(i) <= span_hi);
      end
   end

   assign closed_mask = mask_ff | span_mask;
   assign number_ok   = !ovf_ff && (acc_ff != '0);

   // acc * 10 + digit as shifts
   assign digit_v = VW'(item.digit);
   assign next_v  = (VW'(acc_ff) << 3) + (VW'(acc_ff) << 1) + digit_v;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      end_err  = err_ff;
      end_mask = mask_ff;
      if (err_ff == clrm_pkg::ST_OK) begin
         unique case (phase_ff)
            PH_SPACED: end_err = clrm_pkg::ST_DIGIT;
            PH_NUMBER, PH_AFTER: begin
               if (number_ok) begin
                  end_mask = closed_mask;
               end else begin
                  end_err = clrm_pkg::ST_RANGE;
               end
            end
            default: end_err = err_ff;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      range_open_in = range_open_ff;
      range_low_in  = range_low_ff;
      mask_in       = mask_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_status_in = rsp_status_ff;
      item_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (item_valid) begin
         if (item.cls == clrm_pkg::CLS_END) begin
            // terminator waits until the output register is free
            if (out_free) begin
               item_ready    = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_mask_in   = (end_err == clrm_pkg::ST_OK) ?
                               clrm_pkg::MASK_W'(end_mask) : '0;
               rsp_status_in = end_err;
               phase_in      = PH_EXPECT;
               acc_in        = '0;
               ovf_in        = 1'b0;
               range_open_in = 1'b0;
               range_low_in  = '0;
               mask_in       = '0;
               err_in        = clrm_pkg::ST_OK;
            end
         end else begin
            item_ready = 1'b1;
            if (err_ff == clrm_pkg::ST_OK) begin
               priority if (phase_ff == PH_EXPECT || phase_ff == PH_SPACED) begin
                  unique case (item.cls)
                     clrm_pkg::CLS_BLANK: phase_in = PH_SPACED;
                     clrm_pkg::CLS_DIGIT: begin
                        acc_in   = AW'(item.digit);
                        ovf_in   = digit_v > MAX_V;
                        phase_in = PH_NUMBER;
                     end
                     default: err_in = clrm_pkg::ST_DIGIT;
                  endcase
               end else if (phase_ff == PH_NUMBER && item.cls == clrm_pkg::CLS_DIGIT) begin
                  if (!ovf_ff) begin
                     if (next_v > MAX_V) begin
                        ovf_in = 1'b1;
                     end else begin
                        acc_in = next_v[AW-1:0];
                     end
                  end
               end else if (item.cls == clrm_pkg::CLS_BLANK) begin
                  phase_in = PH_AFTER;
               end else if (!number_ok) begin
                  err_in = clrm_pkg::ST_RANGE;
               end else begin
                  unique case (item.cls)
                     clrm_pkg::CLS_HYPHEN: begin
                        if (range_open_ff) begin
                           err_in = clrm_pkg::ST_HYPHEN;
                        end else begin
                           range_open_in = 1'b1;
                           range_low_in  = hi_raw;
                           phase_in      = PH_EXPECT;
                        end
                     end
                     clrm_pkg::CLS_COMMA: begin
                        mask_in       = closed_mask;
                        range_open_in = 1'b0;
                        range_low_in  = '0;
                        phase_in      = PH_EXPECT;
                     end
                     default: err_in = clrm_pkg::ST_SEPARATOR;
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_EXPECT;
         acc_ff        <= '0;
         ovf_ff        <= 1'b0;
         range_open_ff <= 1'b0;
         range_low_ff  <= '0;
         mask_ff       <= '0;
         err_ff        <= clrm_pkg::ST_OK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         ovf_ff        <= ovf_in;
         range_open_ff <= range_open_in;
         range_low_ff  <= range_low_in;
         mask_ff       <= mask_in;
         err_ff        <= err_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_mask_ff   <= rsp_mask_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel_mask = rsp_mask_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

// File: design/channel_range_list_to_mask.sv
// one character item accepted per cycle, sustained unless a waiting result backs up the queue
// the result for a list passes, once its zero byte is accepted, through the
// classifier register, then a two-entry queue, then the parser's output register
// a waiting result stalls the parser only at a zero byte; the front keeps filling the queue until it is full
// synchronous active-high reset empties the queue and starts a fresh list
`default_nettype none

`include "channel_range_list_to_mask_assert.svh"

module channel_range_list_to_mask #(
   parameter int MAX_CHANNELS = clrm_pkg::MAX_CHANNELS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [clrm_pkg::CHAR_W-1:0]   req_character,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [clrm_pkg::MASK_W-1:0]        rsp_channel_mask,
   output logic [clrm_pkg::STATUS_W-1:0]      rsp_status
);

   logic                      front_valid, front_ready;
   clrm_pkg::char_item_type   front_item;
   logic                      queue_valid, queue_ready;
   clrm_pkg::char_item_type   queue_item;

   clrm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_character (req_character),
      .item_valid    (front_valid),
      .item_ready    (front_ready),
      .item          (front_item)
   );

   clrm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   clrm_back #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (queue_valid),
      .item_ready       (queue_ready),
      .item             (queue_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel_mask (rsp_channel_mask),
      .rsp_status       (rsp_status)
   );

   // an error result never carries mask bits
   `CLRM_ASSERT_IMPL(a_err_mask_zero, clock, reset, rsp_valid && rsp_status != clrm_pkg::ST_OK, rsp_channel_mask == '0)
   `CLRM_ASSERT_IMPL(a_status_legal, clock, reset, rsp_valid, rsp_status <= clrm_pkg::ST_SEPARATOR)
   // no channel beyond the configured count
   `CLRM_ASSERT_IMPL(a_mask_in_range, clock, reset, rsp_valid, (rsp_channel_mask >> MAX_CHANNELS) == '0)
   `CLRM_ASSERT_NEXT(a_reset_no_rsp, clock, reset, !rsp_valid)

endmodule

`default_nettype wire

// File: test/tb_channel_range_list_to_mask.sv
`default_nettype none

module tb_channel_range_list_to_mask;

   localparam logic [7:0] CH_END    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_HYPHEN = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam int CHANNELS  = clrm_pkg::MAX_CHANNELS_DEFAULT;
   localparam int RANDOM_CHARS = 1800;
   localparam int AW = clrm_pkg::ACC_W;
   localparam int IW = clrm_pkg::IDX_W;

   typedef enum logic [1:0] {
      PH_START,
      PH_SPACED,
      PH_DIGITS,
      PH_TRAILING
   } parse_phase_type;

   typedef struct {
      logic [clrm_pkg::MASK_W-1:0] mask;
      clrm_pkg::status_type        status;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [clrm_pkg::CHAR_W-1:0] req_character = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [clrm_pkg::MASK_W-1:0] rsp_channel_mask;
   logic [clrm_pkg::STATUS_W-1:0] rsp_status;

   channel_range_list_to_mask DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_character    (req_character),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel_mask (rsp_channel_mask),
      .rsp_status       (rsp_status)
   );

   always #5 clock = ~clock;

   // parser state mirrored by the predictor
   parse_phase_type             parse_phase;
   logic [AW-1:0]               num_value;
   bit                          num_over;
   bit                          hyphen_pending;
   logic [IW-1:0]               span_start;
   logic [clrm_pkg::MASK_W-1:0] mask_acc;
   clrm_pkg::status_type        first_error;

   list_result_type expected_lists[$];
   logic [7:0]      pending_chars[$];

   int  chars_queued = 0;
   int  chars_sent = 0;
   int  lists_checked = 0;
   int  lists_failed_status = 0;
   int  mismatches = 0;
   bit  req_fire = 0;
   int  send_gap = 0;
   int  send_calm = 0;
   int  recv_gap = 0;
   int  recv_calm = 0;
   int  hold_left = 0;
   int  next_hold_at = 10;

   function automatic void clear_parser();
      parse_phase    = PH_START;
      num_value      = '0;
      num_over       = 0;
      hyphen_pending = 0;
      span_start     = '0;
      mask_acc       = '0;
      first_error    = clrm_pkg::ST_OK;
   endfunction

   function automatic bit number_valid();
      if (num_over || num_value == 0) begin
         first_error = clrm_pkg::ST_RANGE;
         return 0;
      end
      return 1;
   endfunction

   // set the channels between the open range start (or the number alone) and the number, in either order
   function automatic void add_span();
      logic [IW-1:0] top;
      logic [IW-1:0] bottom;
      logic [IW-1:0] swap;
      top = IW'(num_value - 1);
      bottom = hyphen_pending ? span_start : top;
      if (bottom > top) begin
         swap = bottom;
         bottom = top;
         top = swap;
      end
      for (int i = int'(bottom); i <= int'(top); i++)
         mask_acc[i] = 1'b1;
      hyphen_pending = 0;
      span_start = '0;
   endfunction

   function automatic void parse_character(input logic [7:0] ch);
      bit blank;
      bit digit;
      int unsigned sum;
      blank = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
      digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      if (ch == CH_END) begin
         if (first_error == clrm_pkg::ST_OK) begin
            if (parse_phase == PH_SPACED)
               first_error = clrm_pkg::ST_DIGIT;
            else if (parse_phase == PH_DIGITS || parse_phase == PH_TRAILING) begin
               if (number_valid())
                  add_span();
            end
         end
         expected_lists.push_back('{(first_error == clrm_pkg::ST_OK) ? mask_acc : '0,
                                    first_error});
         clear_parser();
      end else if (first_error != clrm_pkg::ST_OK) begin
         // everything up to the terminator is dropped
      end else if (parse_phase == PH_START || parse_phase == PH_SPACED) begin
         if (blank)
            parse_phase = PH_SPACED;
         else if (digit) begin
            num_value = AW'(ch - CH_ZERO);
            num_over = 0;
            parse_phase = PH_DIGITS;
         end else
            first_error = clrm_pkg::ST_DIGIT;
      end else if (parse_phase == PH_DIGITS && digit) begin
         if (!num_over) begin
            sum = num_value * 10 + (ch - CH_ZERO);
            if (sum > CHANNELS)
               num_over = 1;
            else
               num_value = AW'(sum);
         end
      end else if (blank) begin
         parse_phase = PH_TRAILING;
      end else if (number_valid()) begin
         if (ch == CH_HYPHEN) begin
            if (hyphen_pending)
               first_error = clrm_pkg::ST_HYPHEN;
            else begin
               hyphen_pending = 1;
               span_start = IW'(num_value - 1);
               parse_phase = PH_START;
            end
         end else if (ch == CH_COMMA) begin
            add_span();
            parse_phase = PH_START;
         end else
            first_error = clrm_pkg::ST_SEPARATOR;
      end
   endfunction

   // mostly back to back, some short gaps, a few long ones, and calm stretches
   function automatic int next_gap(ref int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 99) == 0)
         calm = $urandom_range(20, 80);
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void queue_list(ref logic [7:0] text[$]);
      foreach (text[i])
         pending_chars.push_back(text[i]);
      pending_chars.push_back(CH_END);
      chars_queued += text.size() + 1;
   endfunction

   function automatic void queue_text(input string s);
      logic [7:0] text[$];
      for (int i = 0; i < s.len(); i++)
         text.push_back(s[i]);
      queue_list(text);
   endfunction

   function automatic void add_blanks(ref logic [7:0] text[$]);
      int k;
      repeat ($urandom_range(1, 2)) begin
         k = $urandom_range(0, 5);
         text.push_back((k == 5) ? CH_SPACE : CH_TAB + 8'(k));
      end
   endfunction

   function automatic void add_number(ref logic [7:0] text[$]);
      int r;
      int n;
      string s;
      r = $urandom_range(0, 99);
      if (r < 72)
         n = $urandom_range(1, CHANNELS);
      else if (r < 88)
         n = ($urandom_range(0, 1) == 1) ? CHANNELS : 1;
      else if (r < 92)
         n = 0;
      else if (r < 97)
         n = $urandom_range(CHANNELS + 1, 200);
      else
         n = $urandom_range(1000, 9999999);
      s = $sformatf("%0d", n);
      if ($urandom_range(0, 9) == 0)
         text.push_back(CH_ZERO);
      for (int i = 0; i < s.len(); i++)
         text.push_back(s[i]);
   endfunction

   function automatic void queue_random_list();
      logic [7:0] text[$];
      int entries;
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 8))
            text.push_back(8'($urandom_range(1, 255)));
      end else begin
         entries = $urandom_range(1, 6);
         for (int i = 0; i < entries; i++) begin
            if (i > 0)
               text.push_back(CH_COMMA);
            if ($urandom_range(0, 3) == 0) add_blanks(text);
            add_number(text);
            if ($urandom_range(0, 9) < 3) begin
               if ($urandom_range(0, 3) == 0) add_blanks(text);
               text.push_back(CH_HYPHEN);
               if ($urandom_range(0, 3) == 0) add_blanks(text);
               add_number(text);
               if ($urandom_range(0, 19) == 0) begin
                  text.push_back(CH_HYPHEN);
                  add_number(text);
               end
            end
            if ($urandom_range(0, 3) == 0) add_blanks(text);
         end
         if ($urandom_range(0, 19) == 0)
            text.push_back(($urandom_range(0, 1) == 1) ? CH_COMMA : CH_HYPHEN);
         // a broken list now and then
         if ($urandom_range(0, 99) < 12)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(1, 255));
      end
      queue_list(text);
   endfunction

   initial begin
      clear_parser();
      queue_text("");
      queue_text("1,3,6-8");
      queue_text("64-1");
      queue_text(" 5 ,\t7\r");
      queue_text("3,");
      queue_text("9-");
      queue_text(" ");
      queue_text("a");
      queue_text("0");
      queue_text("65");
      queue_text("1-2-3");
      queue_text("5 6");
      queue_text("5x\377,1");
      queue_text("2-4,6-8");
      chars_queued = 0;
      while (chars_queued < RANDOM_CHARS)
         queue_random_list();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_chars.size() > 0 || req_valid)
         @(posedge clock);
      while (expected_lists.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d characters sent, %0d lists checked, %0d with an error status",
               chars_sent, lists_checked, lists_failed_status);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #20000000;
      $display("timeout with %0d lists still outstanding", expected_lists.size());
      $display("Simulation FAILED");
      $finish;
   end

   // character sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_chars.size() > 0) begin
            req_valid <= 1'b1;
            req_character <= pending_chars.pop_front();
            chars_sent++;
            send_gap = next_gap(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver, with a few long hold-offs so the input backs up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (lists_checked >= next_hold_at) begin
         hold_left = 250;
         next_hold_at = next_hold_at * 10;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         recv_gap = next_gap(recv_calm);
      end
   end

   always @(posedge clock) begin
      list_result_type oldest;
      req_fire = !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            lists_checked++;
            if (rsp_status != clrm_pkg::ST_OK)
               lists_failed_status++;
            if (expected_lists.size() == 0) begin
               $display("%0t: unexpected result, expected none, got mask %h status %0d",
                        $time, rsp_channel_mask, rsp_status);
               mismatches++;
            end else begin
               oldest = expected_lists.pop_front();
               if (rsp_channel_mask !== oldest.mask) begin
                  $display("%0t: channel mask mismatch, expected %h, got %h",
                           $time, oldest.mask, rsp_channel_mask);
                  mismatches++;
               end
               if (rsp_status !== oldest.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, oldest.status, rsp_status);
                  mismatches++;
               end
            end
         end
         if (req_fire)
            parse_character(req_character);
      end
   end

endmodule

`default_nettype wire
